// File: hw/rtl/ipvrs_pkg.sv
`timescale 1ns / 1ps
package ipvrs_pkg;

	localparam int WAYS        = 16;
	localparam int POS_W       = 4;
	localparam int WAY_W       = 4;
	localparam int MODE_W      = 2;
	localparam int SET_IN_W    = 6;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int DEF_SETS    = 64;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [POS_W-1:0]      LAST_POS          = 4'd15;
	localparam logic [CFG_DATA_W-1:0] RESET_PROMOTE_LOW  = 32'd553844992;
	localparam logic [CFG_DATA_W-1:0] RESET_PROMOTE_HIGH = 32'd2969572609;
	localparam logic [POS_W-1:0]      RESET_INSERT       = 4'd13;

	typedef logic [WAYS-1:0][POS_W-1:0] word_t;
	typedef logic [WAYS-1:0]            valid_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_HIT,
		MODE_FILL,
		MODE_INVAL,
		MODE_QUERY
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROMOTE_LOW,
		CFG_PROMOTE_HIGH,
		CFG_INSERT_POS,
		CFG_UNUSED
	} cfg_idx_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_EXEC
	} back_state_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] promote_high;
		logic [CFG_DATA_W-1:0] promote_low;
		logic [POS_W-1:0]      insert_pos;
	} cfg_t;

	// set address width for a given set count
	function automatic int set_bits(int sets);
		return (sets > 1) ? $clog2(sets) : 1;
	endfunction

	function automatic word_t identity_word();
		word_t w;
		for (int i = 0; i < WAYS; i++) begin
			w[i] = POS_W'(i);
		end
		return w;
	endfunction

endpackage

// File: hw/rtl/ipvrs_front.sv
`timescale 1ns / 1ps
module ipvrs_front
	import ipvrs_pkg::*;
#(
	parameter int SETS = DEF_SETS
) (
	input  logic                                  start,
	input  logic                                  busy,
	input  logic [MODE_W-1:0]                     mode,
	input  logic [SET_IN_W-1:0]                   set_index,
	input  logic [WAY_W-1:0]                      way,
	output logic                                  push,
	output logic [MODE_W+set_bits(SETS)+WAY_W-1:0] item
);

	localparam int SET_W = set_bits(SETS);

	logic [SET_IN_W-1:0] set_red;

	// set_index mod SETS by restoring subtraction of SETS << k
	always_comb begin
		set_red = set_index;
		for (int k = SET_IN_W - 1; k >= 0; k--) begin
			if (32'(set_red) >= (32'(SETS) << k)) begin
				set_red = set_red - SET_IN_W'(32'(SETS) << k);
			end
		end
	end

	assign push = start & ~busy;
	assign item = {mode, SET_W'(set_red), way};

endmodule

// File: hw/rtl/ipvrs_queue.sv
`timescale 1ns / 1ps
module ipvrs_queue
	import ipvrs_pkg::*;
#(
	parameter int W     = 12,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] head,
	output logic         empty,
	output logic         full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]     entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (PTR_W+1)'(DEPTH));
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue pop while empty");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not advance on push");
`endif

endmodule

// File: hw/rtl/ipvrs_back.sv
`timescale 1ns / 1ps
module ipvrs_back
	import ipvrs_pkg::*;
#(
	parameter int SETS = DEF_SETS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  cfg_t                                   cfg,
	input  logic                                   q_empty,
	input  logic [MODE_W+set_bits(SETS)+WAY_W-1:0] q_head,
	output logic                                   q_pop,
	output logic                                   clearing,
	output logic                                   done,
	output logic [WAY_W-1:0]                       victim_way,
	output logic                                   victim_was_invalid,
	output logic [POS_W-1:0]                       new_position
);

	localparam int SET_W  = set_bits(SETS);
	localparam int ITEM_W = MODE_W + SET_W + WAY_W;

	// set memories
	word_t  pos_mem [SETS];
	valid_t val_mem [SETS];

	back_state_t state_q, state_d;
	logic [SET_W-1:0]  clr_q;
	logic [ITEM_W-1:0] item_q;
	word_t             rd_pos_q;
	valid_t            rd_val_q;

	logic              mem_re;
	logic              mem_we;
	logic [SET_W-1:0]  mem_waddr;
	word_t             mem_wpos;
	valid_t            mem_wval;

	mode_t             ex_mode;
	logic [SET_W-1:0]  ex_set;
	logic [WAY_W-1:0]  ex_way;
	word_t             ipv;
	word_t             new_word;
	valid_t            new_valid;
	logic [POS_W-1:0]  cur_p;
	logic [POS_W-1:0]  tgt;

	logic              s2_v;
	word_t             word_s2;
	valid_t            valid_s2;
	logic [POS_W-1:0]  pos_s2;

	logic [WAYS-1:0]   last15;
	logic [WAY_W-1:0]  vic;
	logic              vic_inv;

	logic              done_q;
	logic [WAY_W-1:0]  victim_q;
	logic              victim_inv_q;
	logic [POS_W-1:0]  new_pos_q;

	assign ex_mode = mode_t'(item_q[ITEM_W-1 -: MODE_W]);
	assign ex_set  = item_q[WAY_W +: SET_W];
	assign ex_way  = item_q[WAY_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_CLEAR: if (clr_q == SET_W'(SETS - 1)) state_d = B_IDLE;
			B_IDLE:  if (!q_empty) state_d = B_EXEC;
			B_EXEC:  state_d = B_IDLE;
			default: state_d = B_CLEAR;
		endcase
	end

	// control outputs
	always_comb begin
		q_pop     = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = ex_set;
		mem_wpos  = new_word;
		mem_wval  = new_valid;
		clearing  = 1'b0;
		unique case (state_q)
			B_CLEAR: begin
				clearing  = 1'b1;
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wpos  = identity_word();
				mem_wval  = '0;
			end
			B_IDLE: begin
				q_pop  = ~q_empty;
				mem_re = ~q_empty;
			end
			B_EXEC: begin
				mem_we = 1'b1;
			end
			default: begin
				clearing = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pos_mem[mem_waddr] <= mem_wpos;
			val_mem[mem_waddr] <= mem_wval;
		end
		if (mem_re) begin
			rd_pos_q <= pos_mem[q_head[WAY_W +: SET_W]];
			rd_val_q <= val_mem[q_head[WAY_W +: SET_W]];
		end
	end

	// on a hit or fill, move the addressed way, shifting the ways in between by one
	always_comb begin
		ipv       = word_t'({cfg.promote_high, cfg.promote_low});
		cur_p     = rd_pos_q[ex_way];
		tgt       = (ex_mode == MODE_HIT) ? ipv[cur_p] : cfg.insert_pos;
		new_word  = rd_pos_q;
		new_valid = rd_val_q;
		if (ex_mode == MODE_HIT || ex_mode == MODE_FILL) begin
			for (int v = 0; v < WAYS; v++) begin
				if (WAY_W'(v) != ex_way) begin
					if (tgt < cur_p && rd_pos_q[v] >= tgt && rd_pos_q[v] < cur_p) begin
						new_word[v] = rd_pos_q[v] + 1'b1;
					end else if (tgt > cur_p && rd_pos_q[v] > cur_p && rd_pos_q[v] <= tgt) begin
						new_word[v] = rd_pos_q[v] - 1'b1;
					end
				end
			end
			new_word[ex_way] = tgt;
		end
		unique case (ex_mode)
			MODE_FILL:  new_valid[ex_way] = 1'b1;
			MODE_INVAL: new_valid[ex_way] = 1'b0;
			default:    new_valid = rd_val_q;
		endcase
	end

	// victim: lowest invalid way, else the way at the last position
	always_comb begin
		vic     = '0;
		vic_inv = 1'b0;
		for (int v = 0; v < WAYS; v++) begin
			last15[v] = (word_s2[v] == LAST_POS);
		end
		for (int v = WAYS - 1; v >= 0; v--) begin
			if (last15[v]) vic = WAY_W'(v);
		end
		for (int v = WAYS - 1; v >= 0; v--) begin
			if (!valid_s2[v]) begin
				vic     = WAY_W'(v);
				vic_inv = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_head;
		end
		if (state_q == B_EXEC) begin
			word_s2  <= new_word;
			valid_s2 <= new_valid;
			pos_s2   <= new_word[ex_way];
		end
		if (s2_v) begin
			victim_q     <= vic;
			victim_inv_q <= vic_inv;
			new_pos_q    <= pos_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q   <= '0;
			s2_v    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			s2_v   <= (state_q == B_EXEC);
			done_q <= s2_v;
		end
	end

	assign done               = done_q;
	assign victim_way         = victim_q;
	assign victim_was_invalid = victim_inv_q;
	assign new_position       = new_pos_q;

`ifndef SYNTHESIS
	a_perm_kept: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v |-> $onehot(last15))
		else $error("recency stack lost its permutation");
	a_exec_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_EXEC) |-> ($past(state_q) == B_IDLE && $past(q_pop)))
		else $error("update without a preceding read");
	a_quiet_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_CLEAR) |-> (!done_q && !q_pop))
		else $error("activity during clearing pass");
`endif

endmodule

// File: hw/rtl/ipv_recency_stack_replacement_unit.sv
`timescale 1ns / 1ps
// An accepted start passes the queue, the set-memory read, the update stage and the
// output registers before done rises; a new item is read once the last is written.
// A 2-entry queue between front and back absorbs starts; busy is high when it is full.
// Reset: registers clear at once, then a clearing pass writes every set with busy held
// high; config writes are taken meanwhile. The receiver cannot stall.
module ipv_recency_stack_replacement_unit
	import ipvrs_pkg::*;
#(
	parameter int SETS = DEF_SETS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [MODE_W-1:0]     mode,
	input  logic [SET_IN_W-1:0]   set_index,
	input  logic [WAY_W-1:0]      way,
	output logic                  done,
	output logic [WAY_W-1:0]      victim_way,
	output logic                  victim_was_invalid,
	output logic [POS_W-1:0]      new_position,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int ITEM_W = MODE_W + SET_W + WAY_W;

	cfg_t              cfg_q;
	logic              push;
	logic [ITEM_W-1:0] push_item;
	logic [ITEM_W-1:0] q_head;
	logic              q_empty;
	logic              q_full;
	logic              q_pop;
	logic              clearing;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.promote_low  <= RESET_PROMOTE_LOW;
			cfg_q.promote_high <= RESET_PROMOTE_HIGH;
			cfg_q.insert_pos   <= RESET_INSERT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_PROMOTE_LOW:  cfg_q.promote_low  <= cfg_data;
				CFG_PROMOTE_HIGH: cfg_q.promote_high <= cfg_data;
				CFG_INSERT_POS:   cfg_q.insert_pos   <= cfg_data[POS_W-1:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	assign busy = q_full | clearing;

	ipvrs_front #(
		.SETS(SETS)
	) u_front (
		.start    (start),
		.busy     (busy),
		.mode     (mode),
		.set_index(set_index),
		.way      (way),
		.push     (push),
		.item     (push_item)
	);

	ipvrs_queue #(
		.W    (ITEM_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_item),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	ipvrs_back #(
		.SETS(SETS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.q_empty           (q_empty),
		.q_head            (q_head),
		.q_pop             (q_pop),
		.clearing          (clearing),
		.done              (done),
		.victim_way        (victim_way),
		.victim_was_invalid(victim_was_invalid),
		.new_position      (new_position)
	);

endmodule

// File: verif/ipv_recency_stack_replacement_unit_tb.sv
`timescale 1ns / 1ps
module ipv_recency_stack_replacement_unit_tb;
	import ipvrs_pkg::*;

	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 255;
	localparam int SETTLE_CYCLES   = 8;
	localparam int STALL_LIMIT     = 2000;
	localparam int MAX_REPORTS     = 10;

	typedef struct packed {
		logic [WAY_W-1:0] victim;
		logic             was_invalid;
		logic [POS_W-1:0] pos;
	} access_result_t;

	typedef struct {
		bit                    is_cfg;
		cfg_idx_t              idx;
		logic [CFG_DATA_W-1:0] data;
		mode_t                 op;
		logic [SET_IN_W-1:0]   set_sel;
		logic [WAY_W-1:0]      way_sel;
		bit                    typed;
		access_result_t        want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [MODE_W-1:0]     mode;
	logic [SET_IN_W-1:0]   set_index;
	logic [WAY_W-1:0]      way;
	logic                  done;
	logic [WAY_W-1:0]      victim_way;
	logic                  victim_was_invalid;
	logic [POS_W-1:0]      new_position;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predictor state
	word_t                 stack_pos [DEF_SETS];
	valid_t                way_valid [DEF_SETS];
	logic [CFG_DATA_W-1:0] promo_lo;
	logic [CFG_DATA_W-1:0] promo_hi;
	logic [POS_W-1:0]      fill_pos;

	access_result_t pending_results[$];
	stim_row_t      stim_rows[$];

	int mismatches;
	int results_seen;
	int reg_writes;
	int idle_cycles;
	int op_count[4];

	ipv_recency_stack_replacement_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.set_index(set_index),
		.way(way),
		.done(done),
		.victim_way(victim_way),
		.victim_was_invalid(victim_was_invalid),
		.new_position(new_position),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// move way w to position t; ways in between slide one step toward w's old slot
	function automatic word_t reorder(word_t wd, logic [WAY_W-1:0] w, logic [POS_W-1:0] t);
		word_t            nw;
		logic [POS_W-1:0] p;
		nw = wd;
		p  = wd[w];
		for (int v = 0; v < WAYS; v++) begin
			if (v != w) begin
				if (t < p && wd[v] >= t && wd[v] < p)
					nw[v] = wd[v] + 1'b1;
				else if (t > p && wd[v] > p && wd[v] <= t)
					nw[v] = wd[v] - 1'b1;
			end
		end
		nw[w] = t;
		return nw;
	endfunction

	function automatic logic [WAY_W-1:0] pick_victim(word_t wd, valid_t vl, output logic was_inv);
		logic [WAY_W-1:0] vic;
		vic     = '0;
		was_inv = 1'b0;
		for (int v = 0; v < WAYS; v++) begin
			if (!was_inv && !vl[v]) begin
				vic     = v[WAY_W-1:0];
				was_inv = 1'b1;
			end
		end
		if (!was_inv) begin
			for (int v = 0; v < WAYS; v++) begin
				if (wd[v] == LAST_POS)
					vic = v[WAY_W-1:0];
			end
		end
		return vic;
	endfunction

	function automatic access_result_t update_set(mode_t op, logic [SET_IN_W-1:0] s,
			logic [WAY_W-1:0] w);
		word_t            wd;
		valid_t           vl;
		logic [POS_W-1:0] p;
		logic [POS_W-1:0] tgt;
		access_result_t   r;
		wd = stack_pos[s];
		vl = way_valid[s];
		p  = wd[w];
		case (op)
			MODE_HIT: begin
				tgt = p[3] ? promo_hi[p[2:0]*4 +: 4] : promo_lo[p[2:0]*4 +: 4];
				wd  = reorder(wd, w, tgt);
			end
			MODE_FILL: begin
				wd    = reorder(wd, w, fill_pos);
				vl[w] = 1'b1;
			end
			MODE_INVAL: begin
				vl[w] = 1'b0;
			end
			default: begin
			end
		endcase
		stack_pos[s] = wd;
		way_valid[s] = vl;
		r.victim = pick_victim(wd, vl, r.was_invalid);
		r.pos    = wd[w];
		return r;
	endfunction

	function automatic stim_row_t item_row(mode_t op, logic [SET_IN_W-1:0] s,
			logic [WAY_W-1:0] w);
		stim_row_t r;
		r         = '{idx: CFG_PROMOTE_LOW, op: MODE_HIT, default: '0};
		r.op      = op;
		r.set_sel = s;
		r.way_sel = w;
		return r;
	endfunction

	function automatic stim_row_t typed_row(mode_t op, logic [SET_IN_W-1:0] s,
			logic [WAY_W-1:0] w, logic [WAY_W-1:0] vic, logic inv, logic [POS_W-1:0] p);
		stim_row_t r;
		r       = item_row(op, s, w);
		r.typed = 1'b1;
		r.want  = '{victim: vic, was_invalid: inv, pos: p};
		return r;
	endfunction

	function automatic stim_row_t cfg_row(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		stim_row_t r;
		r        = '{idx: CFG_PROMOTE_LOW, op: MODE_HIT, default: '0};
		r.is_cfg = 1'b1;
		r.idx    = idx;
		r.data   = data;
		return r;
	endfunction

	function automatic void add_row(stim_row_t r);
		stim_rows = {stim_rows, r};
	endfunction

	task automatic program_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_PROMOTE_LOW:  promo_lo = data;
			CFG_PROMOTE_HIGH: promo_hi = data;
			CFG_INSERT_POS:   fill_pos = data[POS_W-1:0];
			default: begin
			end
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_access(mode_t op, logic [SET_IN_W-1:0] s, logic [WAY_W-1:0] w,
			int gap, bit typed, access_result_t want);
		access_result_t pred;
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start     <= 1'b1;
		mode      <= op;
		set_index <= s;
		way       <= w;
		do @(posedge clk); while (busy);
		pred = update_set(op, s, w);
		pending_results = {pending_results, (typed ? want : pred)};
		op_count[op]++;
	endtask

	task automatic stop_access();
		@(negedge clk);
		start <= 1'b0;
	endtask

	// sender holds off until the block has answered everything
	task automatic drain();
		stop_access();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic note_mismatch(string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// result checker
	always @(posedge clk) begin
		access_result_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				note_mismatch($sformatf("unexpected beat victim=%0d inv=%0d pos=%0d",
					victim_way, victim_was_invalid, new_position));
			end else begin
				want = pending_results.pop_front();
				if (victim_way !== want.victim || victim_was_invalid !== want.was_invalid
						|| new_position !== want.pos)
					note_mismatch($sformatf("exp victim=%0d inv=%0d pos=%0d, got %0d %0d %0d",
						want.victim, want.was_invalid, want.pos,
						victim_way, victim_was_invalid, new_position));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t             row;
		access_result_t        none;
		logic [SET_IN_W-1:0]   s;
		logic [WAY_W-1:0]      w;
		logic [CFG_DATA_W-1:0] lo_val;
		logic [CFG_DATA_W-1:0] hi_val;
		logic [POS_W-1:0]      ins_val;
		logic                  inv_flag;
		mode_t                 op;
		int                    pick;
		int                    off;
		int                    gap;
		bit                    burst;

		none         = '0;
		burst        = 1'b0;
		mismatches   = 0;
		results_seen = 0;
		reg_writes   = 0;
		idle_cycles  = 0;
		op_count     = '{default: 0};

		arst_n    = 1'b0;
		start     = 1'b0;
		mode      = '0;
		set_index = '0;
		way       = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;

		for (int i = 0; i < DEF_SETS; i++) begin
			for (int v = 0; v < WAYS; v++)
				stack_pos[i][v] = v[POS_W-1:0];
			way_valid[i] = '0;
		end
		promo_lo = RESET_PROMOTE_LOW;
		promo_hi = RESET_PROMOTE_HIGH;
		fill_pos = RESET_INSERT;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: fresh sets, fill/hit/invalidate, insert extremes, demotion,
		// invalid-way hit, then one set filled until every way is valid
		add_row(typed_row(MODE_QUERY, 6'd0, 4'd0, 4'd0, 1'b1, 4'd0));
		add_row(typed_row(MODE_QUERY, 6'd63, 4'd15, 4'd0, 1'b1, 4'd15));
		add_row(typed_row(MODE_FILL, 6'd0, 4'd0, 4'd1, 1'b1, 4'd13));
		add_row(item_row(MODE_HIT, 6'd0, 4'd0));
		add_row(item_row(MODE_HIT, 6'd0, 4'd7));
		add_row(item_row(MODE_INVAL, 6'd0, 4'd0));
		add_row(cfg_row(CFG_INSERT_POS, 32'd15));
		add_row(typed_row(MODE_FILL, 6'd63, 4'd15, 4'd0, 1'b1, 4'd15));
		add_row(cfg_row(CFG_INSERT_POS, 32'd0));
		add_row(typed_row(MODE_FILL, 6'd63, 4'd0, 4'd1, 1'b1, 4'd0));
		add_row(cfg_row(CFG_PROMOTE_LOW, 32'hFFFF_FFFF));
		add_row(cfg_row(CFG_PROMOTE_HIGH, 32'hFFFF_FFFF));
		add_row(typed_row(MODE_HIT, 6'd63, 4'd0, 4'd1, 1'b1, 4'd15));
		for (int v = 0; v < WAYS; v++)
			add_row(item_row(MODE_FILL, 6'd1, v[WAY_W-1:0]));

		foreach (stim_rows[i]) begin
			row = stim_rows[i];
			if (row.is_cfg) begin
				drain();
				program_reg(row.idx, row.data);
			end else begin
				send_access(row.op, row.set_sel, row.way_sel, $urandom_range(0, 3),
					row.typed, row.want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				0: begin
					lo_val  = RESET_PROMOTE_LOW;
					hi_val  = RESET_PROMOTE_HIGH;
					ins_val = RESET_INSERT;
				end
				1: begin
					lo_val  = '0;
					hi_val  = '0;
					ins_val = '0;
				end
				2: begin
					lo_val  = '1;
					hi_val  = '1;
					ins_val = '1;
				end
				default: begin
					lo_val  = $urandom;
					hi_val  = $urandom;
					ins_val = POS_W'($urandom_range(0, 15));
				end
			endcase
			program_reg(CFG_PROMOTE_LOW, lo_val);
			program_reg(CFG_PROMOTE_HIGH, hi_val);
			program_reg(CFG_INSERT_POS, {28'd0, ins_val});
			// unmapped index must leave everything alone
			program_reg(CFG_UNUSED, $urandom);

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// a few hot sets so that sets fill up and victims come from the stack
				s    = ($urandom_range(0, 99) < 70) ? SET_IN_W'($urandom_range(0, 3))
					: SET_IN_W'($urandom_range(0, 63));
				w    = WAY_W'($urandom_range(0, 15));
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					op  = MODE_HIT;
					off = $urandom_range(0, 15);
					for (int k = WAYS - 1; k >= 0; k--) begin
						if (way_valid[s][(off + k) % WAYS])
							w = WAY_W'((off + k) % WAYS);
					end
				end else if (pick < 65) begin
					op = MODE_FILL;
					w  = pick_victim(stack_pos[s], way_valid[s], inv_flag);
				end else if (pick < 75) begin
					op = MODE_FILL;
				end else if (pick < 85) begin
					op = MODE_INVAL;
				end else if (pick < 95) begin
					op = MODE_QUERY;
				end else begin
					op = mode_t'($urandom_range(0, 3));
					s  = SET_IN_W'($urandom);
				end
				if ($urandom_range(0, 39) == 0)
					burst = !burst;
				gap = burst ? 0 : $urandom_range(0, 10);
				send_access(op, s, w, gap, 1'b0, none);
			end
		end

		drain();
		mismatches += pending_results.size();
		$display("Ran %0d hits, %0d fills, %0d invalidates, %0d queries; %0d beats checked",
			op_count[MODE_HIT], op_count[MODE_FILL], op_count[MODE_INVAL],
			op_count[MODE_QUERY], results_seen);
		$display("Register writes: %0d across %0d settings incl. all-zero and all-one IPV",
			reg_writes, PHASES + 1);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
